// ----- hdl/qrp_pkg.sv -----
// Shared widths, constants, tables and stage records for the quaternion propagation unit.
package qrp_pkg;

  localparam int unsigned QW       = 16;  // quaternion and rate component width
  localparam int unsigned ROOT_W   = 24;  // rate magnitude, 2^-19 rad/s
  localparam int unsigned RAD_W    = 48;  // radicand of the magnitude square root
  localparam int unsigned HALF_W   = 40;  // half angle, 2^-36 rad
  localparam int unsigned ANG_W    = 36;  // CORDIC angle, Q2.30 with headroom
  localparam int unsigned XY_W     = 34;  // CORDIC vector and increment parts
  localparam int unsigned PROD_W   = 50;  // QW x XY_W product
  localparam int unsigned NUM_W    = 56;  // axis dividend
  localparam int unsigned QUO_W    = 32;  // axis quotient
  localparam int unsigned ATAN_N   = 24;  // arctangent table depth
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned NUM_SH   = 8;   // rate times 256
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  localparam logic [STEP_W-1:0]     STEP_RESET  = 16'd655;
  localparam logic [HALF_W-1:0]     TWO_PI_Q36  = 40'h6487ED5111;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sh0C90FDAA2;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sh06487ED51;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sh1921FB544;
  localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sh026DD3B6A;

  // atan(2^-i) in Q2.30, truncated
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // request data that rides along the pipe up to the quaternion multiplier
  typedef struct packed {
    logic [3:0][QW-1:0] quat;  // w, x, y, z
    logic [2:0][QW-1:0] rate;  // x, y, z
    logic               zero;
  } side_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [ROOT_W-1:0] mag8;
    logic [HALF_W-1:0] val;
  } ang_st_t;

  typedef struct packed {
    logic                     valid;
    side_t                    side;
    logic [ROOT_W-1:0]        mag8;
    logic                     flip;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [ANG_W-1:0]  ang;
  } cord_st_t;

  typedef struct packed {
    logic                     valid;
    side_t                    side;
    logic [ROOT_W-1:0]        mag8;
    logic                     flip;
    logic signed [XY_W-1:0]   cs;
    logic [2:0][PROD_W-1:0]   prod;
  } prep_st_t;

  typedef struct packed {
    logic                     valid;
    side_t                    side;
    logic signed [XY_W-1:0]   cs;
    logic [ROOT_W-1:0]        mag8;
    logic [2:0]               neg;
    logic [2:0][NUM_W-1:0]    num;
    logic [2:0][QUO_W-1:0]    quo;
  } div_st_t;

  typedef struct packed {
    logic               valid;
    logic [3:0][QW-1:0] quat;
    logic               zero;
  } res_t;

endpackage

// ----- hdl/qrp_sqrt_cell.sv -----
// One bit of the pipelined integer square root for the rate magnitude.
module qrp_sqrt_cell import qrp_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  sqrt_st_t  cell_i,
  output sqrt_st_t  cell_o
);

  localparam int unsigned TW = RAD_W + 2;

  logic [TW-1:0] trial;
  sqrt_st_t      cell_d, cell_q;

  // try setting this root bit against the remaining radicand
  always_comb begin
    trial  = (TW'(cell_i.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    cell_d = cell_i;
    if ({2'b00, cell_i.rad} >= trial) begin
      cell_d.rad  = cell_i.rad - trial[RAD_W-1:0];
      cell_d.root = cell_i.root | (ROOT_W'(1) << BIT);
    end
  end

  // advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- hdl/qrp_cordic_cell.sv -----
// One rotation step of the CORDIC that yields cosine and sine of the half angle.
module qrp_cordic_cell import qrp_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cord_st_t  cell_i,
  output cord_st_t  cell_o
);

  logic signed [XY_W-1:0]  dx, dy;
  logic signed [ANG_W-1:0] at;
  cord_st_t                cell_d, cell_q;

  // rotate towards zero residual angle
  always_comb begin
    dx     = cell_i.y >>> IDX;
    dy     = cell_i.x >>> IDX;
    at     = $signed(ANG_W'(ATAN_TAB[IDX]));
    cell_d = cell_i;
    if (!cell_i.ang[ANG_W-1]) begin
      cell_d.x   = cell_i.x - dx;
      cell_d.y   = cell_i.y + dy;
      cell_d.ang = cell_i.ang - at;
    end else begin
      cell_d.x   = cell_i.x + dx;
      cell_d.y   = cell_i.y - dy;
      cell_d.ang = cell_i.ang + at;
    end
  end

  // advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- hdl/qrp_div_cell.sv -----
// One quotient bit of the three axis dividers, one lane per rate component.
module qrp_div_cell import qrp_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  div_st_t  cell_i,
  output div_st_t  cell_o
);

  logic [NUM_W-1:0] dsh;
  div_st_t          cell_d, cell_q;

  // restoring step on each lane
  always_comb begin
    dsh    = NUM_W'(cell_i.mag8) << BIT;
    cell_d = cell_i;
    for (int l = 0; l < 3; l++) begin
      if (cell_i.num[l] >= dsh) begin
        cell_d.num[l]      = cell_i.num[l] - dsh;
        cell_d.quo[l][BIT] = 1'b1;
      end
    end
  end

  // advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- hdl/qrp_quat_mult.sv -----
// Hamilton product of the attitude with the increment, rounded and saturated to Q2.14.
module qrp_quat_mult import qrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  div_st_t  div_i,
  output res_t     res_o
);

  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned FRAC  = 30;
  localparam logic signed [SUM_W-1:0] RND    = SUM_W'(1) << (FRAC - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic [3:0][QW-1:0]      quat;
    logic [3:0][XY_W-1:0]    sv;
  } inc_t;

  typedef struct packed {
    logic                        valid;
    logic                        zero;
    logic [3:0][QW-1:0]          quat;
    logic [3:0][3:0][PROD_W-1:0] p;
  } prd_t;

  inc_t inc_d, inc_q;
  prd_t prd_d, prd_q;
  res_t res_d, res_q;
  logic signed [SUM_W-1:0] acc [4];

  function automatic logic signed [SUM_W-1:0] pe(input logic [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] s;
    s = $signed(v);
    return SUM_W'(s);
  endfunction

  function automatic logic [QW-1:0] round_sat(input logic signed [SUM_W-1:0] a);
    logic signed [SUM_W-1:0] r;
    r = (a + RND) >>> FRAC;
    if (r > SAT_HI) begin
      return 16'h7FFF;
    end else if (r < SAT_LO) begin
      return 16'h8000;
    end
    return r[QW-1:0];
  endfunction

  // apply the sign to each axis quotient
  always_comb begin
    inc_d.valid = div_i.valid;
    inc_d.zero  = div_i.side.zero;
    inc_d.quat  = div_i.side.quat;
    inc_d.sv[0] = div_i.cs;
    for (int l = 0; l < 3; l++) begin
      inc_d.sv[l+1] = div_i.neg[l] ? -XY_W'(div_i.quo[l]) : XY_W'(div_i.quo[l]);
    end
  end

  // form all sixteen component products
  always_comb begin
    prd_d.valid = inc_q.valid;
    prd_d.zero  = inc_q.zero;
    prd_d.quat  = inc_q.quat;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        prd_d.p[a][b] = $signed(inc_q.quat[a]) * $signed(inc_q.sv[b]);
      end
    end
  end

  // sum, round and saturate; pass the attitude on a zero rate
  always_comb begin
    acc[0] = pe(prd_q.p[0][0]) - pe(prd_q.p[1][1]) - pe(prd_q.p[2][2]) - pe(prd_q.p[3][3]);
    acc[1] = pe(prd_q.p[0][1]) + pe(prd_q.p[1][0]) + pe(prd_q.p[2][3]) - pe(prd_q.p[3][2]);
    acc[2] = pe(prd_q.p[0][2]) + pe(prd_q.p[2][0]) + pe(prd_q.p[3][1]) - pe(prd_q.p[1][3]);
    acc[3] = pe(prd_q.p[0][3]) + pe(prd_q.p[3][0]) + pe(prd_q.p[1][2]) - pe(prd_q.p[2][1]);
    res_d.valid = prd_q.valid;
    res_d.zero  = prd_q.zero;
    for (int c = 0; c < 4; c++) begin
      res_d.quat[c] = prd_q.zero ? prd_q.quat[c] : round_sat(acc[c]);
    end
  end

  // advance the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q.valid <= 1'b0;
      prd_q.valid <= 1'b0;
      res_q.valid <= 1'b0;
    end else if (en_i) begin
      inc_q <= inc_d;
      prd_q <= prd_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hdl/quaternion_rate_propagation_unit.sv -----
// Top level: propagates an attitude quaternion by one step of constant angular rate.
//
// Input stream (s_axis_*): one request per beat holding the attitude quaternion and the
// three-axis rate. Output stream (m_axis_*): the propagated quaternion, with tuser set
// when the rate was zero and the attitude was passed through unchanged.
// Configuration (cfg_*): writes the 16-bit step time; always ready, reset value 655.
// Write it only while no request is in flight.
// From the accepting edge to tvalid a request passes one input stage, 24 square-root cells,
// three angle stages, the CORDIC cells, two divider set-up stages, 32 divider cells, three
// product stages and the output register. Throughput is one request per cycle while the
// pipe is not held; each square-root, CORDIC and divider cell does one bit or one rotation.
// When the receiver stalls, the finished result waits in the output register while the
// pipe keeps filling its bubbles; only when the last stage is also full does s_axis_tready
// drop and the whole pipe hold. Reset empties every stage and restores the step time.
module quaternion_rate_propagation_unit import qrp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [STEP_W-1:0]   cfg_data_i,      // step_time
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7*QW-1:0]     s_axis_tdata,    // quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [4*QW-1:0]     m_axis_tdata,    // next_w, next_x, next_y, next_z
  output logic                m_axis_tuser     // zero_rate
);

  logic              en, out_free;
  logic [STEP_W-1:0] step_q;

  sqrt_st_t in_d, in_q;
  sqrt_st_t sq_ch [ROOT_W+1];
  ang_st_t  mul_d, mul_q, mod_d, mod_q;
  cord_st_t ang_d, ang_q;
  cord_st_t cd_ch [CORDIC_STAGES+1];
  prep_st_t pre_d, pre_q;
  div_st_t  dv_d, dv_q;
  div_st_t  dv_ch [QUO_W+1];
  res_t     res_last, out_q;

  logic signed [2*QW-1:0]  sq [3];
  logic [2*QW-1:0]         sumsq;
  logic signed [ANG_W-1:0] a0, a1;
  logic [PROD_W-1:0]       pabs;

  // step time register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

  // hold the pipe only when the last stage is full and the output cannot take it
  assign out_free      = !out_q.valid || m_axis_tready;
  assign en            = out_free || !res_last.valid;
  assign s_axis_tready = en;

  // capture the request and form the squared magnitude
  always_comb begin
    in_d.valid     = s_axis_tvalid;
    in_d.side.quat = s_axis_tdata[4*QW-1:0];
    in_d.side.rate = s_axis_tdata[7*QW-1:4*QW];
    for (int i = 0; i < 3; i++) begin
      sq[i] = $signed(in_d.side.rate[i]) * $signed(in_d.side.rate[i]);
    end
    sumsq          = $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);
    in_d.side.zero = (sumsq == '0);
    in_d.rad       = {sumsq, 16'h0000};
    in_d.root      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q.valid <= 1'b0;
    end else if (en) begin
      in_q <= in_d;
    end
  end

  // square root, most significant bit first
  assign sq_ch[0] = in_q;
  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    qrp_sqrt_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (sq_ch[g]),
      .cell_o (sq_ch[g+1])
    );
  end

  // half angle, reduce modulo two pi, then fold into the CORDIC range
  always_comb begin
    mul_d.valid = sq_ch[ROOT_W].valid;
    mul_d.side  = sq_ch[ROOT_W].side;
    mul_d.mag8  = sq_ch[ROOT_W].root;
    mul_d.val   = step_q * sq_ch[ROOT_W].root;

    mod_d = mul_q;
    if (mul_q.val >= (TWO_PI_Q36 << 1)) begin
      mod_d.val = mul_q.val - (TWO_PI_Q36 << 1);
    end else if (mul_q.val >= TWO_PI_Q36) begin
      mod_d.val = mul_q.val - TWO_PI_Q36;
    end

    a0 = $signed(ANG_W'((mod_q.val + HALF_W'(32)) >> 6));
    a1 = (a0 > PI_Q30) ? a0 - TWO_PI_Q30 : a0;
    ang_d.valid = mod_q.valid;
    ang_d.side  = mod_q.side;
    ang_d.mag8  = mod_q.mag8;
    ang_d.x     = GAIN_Q30;
    ang_d.y     = '0;
    ang_d.flip  = 1'b0;
    ang_d.ang   = a1;
    if (a1 > HALF_PI_Q30) begin
      ang_d.ang  = a1 - PI_Q30;
      ang_d.flip = 1'b1;
    end else if (a1 < -HALF_PI_Q30) begin
      ang_d.ang  = a1 + PI_Q30;
      ang_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q.valid <= 1'b0;
      mod_q.valid <= 1'b0;
      ang_q.valid <= 1'b0;
    end else if (en) begin
      mul_q <= mul_d;
      mod_q <= mod_d;
      ang_q <= ang_d;
    end
  end

  // CORDIC rotation cells
  assign cd_ch[0] = ang_q;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    qrp_cordic_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (cd_ch[g]),
      .cell_o (cd_ch[g+1])
    );
  end

  // rate times sine, then magnitude and rounding bias for the dividers
  always_comb begin
    pre_d.valid = cd_ch[CORDIC_STAGES].valid;
    pre_d.side  = cd_ch[CORDIC_STAGES].side;
    pre_d.mag8  = cd_ch[CORDIC_STAGES].mag8;
    pre_d.flip  = cd_ch[CORDIC_STAGES].flip;
    pre_d.cs    = cd_ch[CORDIC_STAGES].flip ? -cd_ch[CORDIC_STAGES].x : cd_ch[CORDIC_STAGES].x;
    for (int l = 0; l < 3; l++) begin
      pre_d.prod[l] = $signed(cd_ch[CORDIC_STAGES].side.rate[l]) * cd_ch[CORDIC_STAGES].y;
    end

    dv_d.valid = pre_q.valid;
    dv_d.side  = pre_q.side;
    dv_d.cs    = pre_q.cs;
    dv_d.mag8  = pre_q.mag8;
    dv_d.quo   = '0;
    pabs       = '0;
    for (int l = 0; l < 3; l++) begin
      pabs        = pre_q.prod[l][PROD_W-1] ? -pre_q.prod[l] : pre_q.prod[l];
      dv_d.neg[l] = pre_q.prod[l][PROD_W-1] ^ pre_q.flip;
      dv_d.num[l] = (NUM_W'(pabs) << NUM_SH) + NUM_W'(pre_q.mag8 >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q.valid <= 1'b0;
      dv_q.valid  <= 1'b0;
    end else if (en) begin
      pre_q <= pre_d;
      dv_q  <= dv_d;
    end
  end

  // axis dividers, one quotient bit per cell
  assign dv_ch[0] = dv_q;
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    qrp_div_cell #(.BIT(QUO_W - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (dv_ch[g]),
      .cell_o (dv_ch[g+1])
    );
  end

  qrp_quat_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .div_i  (dv_ch[QUO_W]),
    .res_o  (res_last)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q.valid <= 1'b0;
    end else if (out_free) begin
      out_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tdata  = out_q.quat;
  assign m_axis_tuser  = out_q.zero;

  // a nonzero rate always has a magnitude of at least one rate unit
  a_root_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_ch[ROOT_W].valid && !sq_ch[ROOT_W].side.zero |-> sq_ch[ROOT_W].root >= ROOT_W'(256))
    else $error("rate magnitude below one unit on a nonzero rate");

  // axis quotients never reach the top bit
  a_quo_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_ch[QUO_W].valid && !dv_ch[QUO_W].side.zero |->
      !dv_ch[QUO_W].quo[0][QUO_W-1] && !dv_ch[QUO_W].quo[1][QUO_W-1] &&
      !dv_ch[QUO_W].quo[2][QUO_W-1])
    else $error("axis quotient overflow");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !res_last.valid |=> !m_axis_tvalid)
    else $error("output result repeated");

endmodule
